// File: design/bpq_pkg.sv
package bpq_pkg;

  typedef enum logic [2:0] {
    PS_RELEASED    = 3'd0,
    PS_PREPRESSED  = 3'd1,
    PS_SHORT       = 3'd2,
    PS_LONG        = 3'd3,
    PS_PRERELEASED = 3'd4
  } press_state_e;

  typedef enum logic [0:0] {
    ACT_SAMPLE = 1'b0,
    ACT_FORCE  = 1'b1
  } action_e;

  localparam int CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_POLARITY  = 2'd1
  } cfg_reg_e;

  localparam int MaxButtons = 8;

  localparam logic [7:0] ThresholdReset = 8'd100;
  localparam logic [7:0] PolarityReset  = 8'd0;
  localparam logic [7:0] HoldMax        = 8'd255;

  typedef struct packed {
    logic       action;
    logic [2:0] button;
    logic       pin_sample;
    logic [2:0] forced_state;
  } in_item_t;

  typedef struct packed {
    logic [2:0] which_button;
    logic [2:0] button_state;
    logic       rejected;
  } out_item_t;

endpackage

// File: design/button_press_qualifier_unit.sv
// Debounce and long-press qualifier for up to eight buttons. Each input transfer either
// applies one pin sample to a button (XORed with that button's polarity bit) or forces
// the button's state, and yields exactly one result transfer with the button's state
// after the update. Out-of-range buttons and invalid forced states are rejected. Every
// item passes through an input register, the state update and a result register, so the
// block takes one item per cycle unless the output stalls. The per-button state and hold
// count are written when an item leaves the input register, so an item for the same
// button in the very next cycle sees the update. Configuration writes are always ready.
module button_press_qualifier_unit #(
  parameter int NUM_BUTTONS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  bpq_pkg::in_item_t                   in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output bpq_pkg::out_item_t                  out_item_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bpq_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [7:0]                          cfg_data_i
);

  localparam int Depth = (NUM_BUTTONS < bpq_pkg::MaxButtons) ? NUM_BUTTONS
                                                             : bpq_pkg::MaxButtons;
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  logic                 in_valid_q;
  bpq_pkg::in_item_t    in_item_q;
  logic                 out_valid_q;
  bpq_pkg::out_item_t   out_item_q;
  logic [7:0]           threshold_q;
  logic [7:0]           polarity_q;
  bpq_pkg::press_state_e state_q [Depth];
  logic [7:0]           hold_q  [Depth];

  logic                  out_free;
  logic                  in_move;
  logic                  in_range;
  logic [IdxW-1:0]       idx;
  logic                  pressed;
  bpq_pkg::press_state_e cur_state;
  logic [7:0]            cur_hold;
  logic [7:0]            hold_inc;
  bpq_pkg::press_state_e state_d;
  logic [7:0]            hold_d;
  logic                  rejected_d;
  bpq_pkg::out_item_t    out_item_d;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_move     = in_valid_q && out_free;
  assign in_stall_o  = in_valid_q && !out_free;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign cfg_ready_o = 1'b1;

  assign in_range  = 32'(in_item_q.button) < NUM_BUTTONS;
  assign idx       = IdxW'(in_item_q.button);
  assign pressed   = in_item_q.pin_sample ^ polarity_q[in_item_q.button];
  assign cur_state = state_q[idx];
  assign cur_hold  = hold_q[idx];
  assign hold_inc  = (cur_hold == bpq_pkg::HoldMax) ? cur_hold : cur_hold + 8'd1;

  always_comb begin
    state_d    = cur_state;
    hold_d     = cur_hold;
    rejected_d = 1'b0;
    if (!in_range) begin
      rejected_d = 1'b1;
    end else if (in_item_q.action == bpq_pkg::ACT_FORCE) begin
      if (in_item_q.forced_state inside {[3'd0:3'd4]}) begin
        state_d = bpq_pkg::press_state_e'(in_item_q.forced_state);
      end else begin
        rejected_d = 1'b1;
      end
    end else begin
      case (cur_state)
        bpq_pkg::PS_RELEASED: begin
          state_d = pressed ? bpq_pkg::PS_PREPRESSED : bpq_pkg::PS_RELEASED;
        end
        bpq_pkg::PS_PREPRESSED: begin
          if (pressed) begin
            state_d = bpq_pkg::PS_SHORT;
            hold_d  = hold_inc;
          end else begin
            state_d = bpq_pkg::PS_PRERELEASED;
          end
        end
        bpq_pkg::PS_SHORT: begin
          if (pressed) begin
            if (cur_hold >= threshold_q) begin
              state_d = bpq_pkg::PS_LONG;
              hold_d  = 8'd0;
            end else begin
              hold_d = hold_inc;
            end
          end else begin
            state_d = bpq_pkg::PS_PRERELEASED;
            hold_d  = 8'd0;
          end
        end
        bpq_pkg::PS_LONG: begin
          state_d = pressed ? bpq_pkg::PS_LONG : bpq_pkg::PS_PRERELEASED;
        end
        bpq_pkg::PS_PRERELEASED: begin
          state_d = pressed ? bpq_pkg::PS_PREPRESSED : bpq_pkg::PS_RELEASED;
        end
        default: begin
          state_d = cur_state;
        end
      endcase
    end
  end

  always_comb begin
    out_item_d.which_button = in_item_q.button;
    out_item_d.button_state = in_range ? 3'(state_d) : 3'(bpq_pkg::PS_RELEASED);
    out_item_d.rejected     = rejected_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (in_move) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_move) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_move) begin
      out_item_q <= out_item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        state_q[i] <= bpq_pkg::PS_RELEASED;
        hold_q[i]  <= 8'd0;
      end
    end else if (in_move && in_range) begin
      state_q[idx] <= state_d;
      hold_q[idx]  <= hold_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= bpq_pkg::ThresholdReset;
      polarity_q  <= bpq_pkg::PolarityReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        bpq_pkg::CFG_THRESHOLD: threshold_q <= cfg_data_i;
        bpq_pkg::CFG_POLARITY:  polarity_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

endmodule

// File: design/bpq_checker.sv
module bpq_checker #(
  parameter int NUM_BUTTONS = 8
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input bpq_pkg::out_item_t out_item_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed or dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while result side free");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##2 out_valid_o)
    else $error("no result after input transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (32'(out_item_o.which_button) >= NUM_BUTTONS) |->
      out_item_o.rejected && (out_item_o.button_state == 3'(bpq_pkg::PS_RELEASED)))
    else $error("missing button not rejected");

endmodule

bind button_press_qualifier_unit bpq_checker #(.NUM_BUTTONS(NUM_BUTTONS)) u_bpq_checker (.*);
